FILE: rtl/core/drpi_pkg.sv
// Shared types and constants for the dead-reckoning pose integrator.
`timescale 1ns / 1ps

package drpi_pkg;

    typedef logic signed [33:0] t_cordic;
    typedef logic signed [67:0] t_prod;

    localparam int unsigned ATAN_DEPTH = 32;

    localparam t_cordic CORDIC_GAIN = 34'sd652032874;
    localparam t_cordic RAD_TO_BAM  = 34'sd2734261102;

    localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

FILE: rtl/core/dead_reckoning_pose_integrator.sv
// Top level: planar pose integrator with a shared CORDIC stage and one shared multiplier.
//
// Input channel (i_in_valid / o_in_ready) carries one odometry item: forward
// speed, yaw rate and elapsed time. Output channel (o_out_valid / i_out_ready)
// carries the updated pose (x, y, heading) and the velocity taken from the old
// heading.
// Each item runs its CORDIC rotations on one shift-add unit, then uses one
// 34x34 multiplier in turn (two velocity products, two position deltas,
// heading rate times time, scaling to binary angle, heading update), then
// loads the result register. No new item is taken until the sequencer has
// gone back to idle; o_in_ready is high only while the sequencer is idle.
// A finished result sits in the output register until taken. The next item is
// accepted meanwhile; if its result is ready before the receiver takes the old
// one, the sequencer holds in its final state.
// Reset clears the pose to zero, empties the output register and idles the
// sequencer.
`timescale 1ns / 1ps

module dead_reckoning_pose_integrator #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_speed,
    input  logic signed [15:0] i_yaw_rate,
    input  logic        [15:0] i_elapsed,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic        [31:0] o_heading_out,
    output logic signed [15:0] o_vel_x,
    output logic signed [15:0] o_vel_y
);

    localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROT  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [2:0] PH_VX    = 3'd0;
    localparam logic [2:0] PH_VY    = 3'd1;
    localparam logic [2:0] PH_DX    = 3'd2;
    localparam logic [2:0] PH_DY    = 3'd3;
    localparam logic [2:0] PH_RATE  = 3'd4;
    localparam logic [2:0] PH_SCALE = 3'd5;
    localparam logic [2:0] PH_HEAD  = 3'd6;

    logic [1:0]            r_state;
    logic [2:0]            r_phase;
    logic [SW-1:0]         r_step;
    logic [1:0]            r_q;
    drpi_pkg::t_cordic     r_x;
    drpi_pkg::t_cordic     r_y;
    drpi_pkg::t_cordic     r_z;
    drpi_pkg::t_prod       r_prod;
    logic signed [15:0]    r_spd;
    logic signed [15:0]    r_rate;
    logic        [15:0]    r_dt;
    logic signed [15:0]    r_vx;
    logic signed [15:0]    r_vy;
    logic signed [31:0]    r_x_acc;
    logic signed [31:0]    r_y_acc;
    logic        [31:0]    r_heading;
    logic                  r_out_valid;
    logic signed [31:0]    r_out_x;
    logic signed [31:0]    r_out_y;
    logic        [31:0]    r_out_head;
    logic signed [15:0]    r_out_vx;
    logic signed [15:0]    r_out_vy;

    logic [31:0]           n_hq;
    logic [1:0]            n_q;
    logic [31:0]           n_u;
    drpi_pkg::t_cordic     n_xs;
    drpi_pkg::t_cordic     n_ys;
    drpi_pkg::t_cordic     n_atan;
    drpi_pkg::t_cordic     n_cos;
    drpi_pkg::t_cordic     n_sin;
    drpi_pkg::t_cordic     n_ma;
    drpi_pkg::t_cordic     n_mb;
    drpi_pkg::t_prod       n_mp;
    drpi_pkg::t_prod       n_vr;
    logic signed [15:0]    n_vsat;
    drpi_pkg::t_prod       n_pr;
    logic signed [33:0]    n_acc;
    logic signed [33:0]    n_psum;
    logic signed [31:0]    n_psat;
    drpi_pkg::t_prod       n_hr;
    logic                  in_fire;
    logic                  out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // quadrant reduction of the old heading
    always_comb begin
        n_hq = r_heading + 32'h2000_0000;
        n_q  = n_hq[31:30];
        n_u  = r_heading - {n_q, 30'd0};
    end

    // CORDIC shift-add unit
    always_comb begin
        n_xs   = r_x >>> r_step;
        n_ys   = r_y >>> r_step;
        n_atan = drpi_pkg::t_cordic'({2'b00, drpi_pkg::ATAN_TAB[5'(r_step)]});
    end

    always_comb begin
        unique case (r_q)
            2'd0: begin n_cos = r_x;  n_sin = r_y;  end
            2'd1: begin n_cos = -r_y; n_sin = r_x;  end
            2'd2: begin n_cos = -r_x; n_sin = -r_y; end
            default: begin n_cos = r_y; n_sin = -r_x; end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (r_phase)
            PH_VX: begin
                n_ma = 34'(r_spd);
                n_mb = n_cos;
            end
            PH_VY: begin
                n_ma = 34'(r_spd);
                n_mb = n_sin;
            end
            PH_DX: begin
                n_ma = 34'(r_vx);
                n_mb = signed'(34'(r_dt));
            end
            PH_DY: begin
                n_ma = 34'(r_vy);
                n_mb = signed'(34'(r_dt));
            end
            PH_RATE: begin
                n_ma = 34'(r_rate);
                n_mb = signed'(34'(r_dt));
            end
            PH_SCALE: begin
                n_ma = 34'(signed'(r_prod[31:0]));
                n_mb = drpi_pkg::RAD_TO_BAM;
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
        n_mp = n_ma * n_mb;
    end

    // rounding and saturation of the registered product
    always_comb begin
        n_vr = (r_prod + 68'sh2000_0000) >>> 30;
        if (n_vr > 68'sd32767) begin
            n_vsat = 16'sh7FFF;
        end else if (n_vr < -68'sd32768) begin
            n_vsat = -16'sh8000;
        end else begin
            n_vsat = n_vr[15:0];
        end

        n_pr   = (r_prod + 68'sh800) >>> 12;
        n_acc  = (r_phase == PH_DY) ? 34'(r_x_acc) : 34'(r_y_acc);
        n_psum = n_acc + signed'(n_pr[33:0]);
        if (n_psum > 34'sd2147483647) begin
            n_psat = 32'sh7FFF_FFFF;
        end else if (n_psum < -34'sd2147483648) begin
            n_psat = -32'sh8000_0000;
        end else begin
            n_psat = n_psum[31:0];
        end

        n_hr = r_prod + 68'sh2000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_VX;
            r_step      <= '0;
            r_x_acc     <= '0;
            r_y_acc     <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_ROT;
                        r_step  <= '0;
                    end
                end
                S_ROT: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= S_MUL;
                        r_phase <= PH_VX;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_MUL: begin
                    case (r_phase)
                        PH_DY:   r_x_acc <= n_psat;
                        PH_RATE: r_y_acc <= n_psat;
                        PH_HEAD: r_heading <= r_heading + n_hr[61:30];
                        default: ;
                    endcase
                    if (r_phase == PH_HEAD) begin
                        r_state <= S_DONE;
                    end else begin
                        r_phase <= r_phase + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_spd  <= i_speed;
            r_rate <= i_yaw_rate;
            r_dt   <= i_elapsed;
            r_q    <= n_q;
            r_x    <= drpi_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= 34'(signed'(n_u));
        end else if (r_state == S_ROT) begin
            if (!r_z[33]) begin
                r_x <= r_x - n_ys;
                r_y <= r_y + n_xs;
                r_z <= r_z - n_atan;
            end else begin
                r_x <= r_x + n_ys;
                r_y <= r_y - n_xs;
                r_z <= r_z + n_atan;
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= n_mp;
            if (r_phase == PH_VY) begin
                r_vx <= n_vsat;
            end
            if (r_phase == PH_DX) begin
                r_vy <= n_vsat;
            end
        end
        if (out_load) begin
            r_out_x    <= r_x_acc;
            r_out_y    <= r_y_acc;
            r_out_head <= r_heading;
            r_out_vx   <= r_vx;
            r_out_vy   <= r_vy;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_out_x;
    assign o_pos_y       = r_out_y;
    assign o_heading_out = r_out_head;
    assign o_vel_x       = r_out_vx;
    assign o_vel_y       = r_out_vy;

endmodule

FILE: verif/pose_checker.sv
// Pose checker: predicts every odometry result and compares it with the block's output.
`timescale 1ns / 1ps

module pose_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [15:0] i_speed,
    input  logic signed [15:0] i_yaw_rate,
    input  logic        [15:0] i_elapsed,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic        [31:0] i_heading_out,
    input  logic signed [15:0] i_vel_x,
    input  logic signed [15:0] i_vel_y,
    output int                 o_failures,
    output int                 o_pending
);

    localparam longint GAIN_Q30       = 64'sd652032874;
    localparam longint RAD_TO_BAM_Q30 = 64'sd2734261102;
    localparam longint POS_MAX        = 64'sd2147483647;
    localparam longint POS_MIN        = -64'sd2147483648;
    localparam longint VEL_MAX        = 64'sd32767;
    localparam longint VEL_MIN        = -64'sd32768;
    localparam int     ROTATIONS      = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [31:0] heading;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
    } pose_t;

    pose_t       expected_poses [$];
    longint      track_x;
    longint      track_y;
    logic [31:0] track_heading;
    int          failures     = 0;
    int          results_seen = 0;

    function automatic logic [31:0] arctan_q30(input int step);
        case (step)
            0:       return 32'h20000000;
            1:       return 32'h12E4051E;
            2:       return 32'h09FB385B;
            3:       return 32'h051111D4;
            4:       return 32'h028B0D43;
            5:       return 32'h0145D7E1;
            6:       return 32'h00A2F61E;
            7:       return 32'h00517C55;
            8:       return 32'h0028BE53;
            9:       return 32'h00145F2F;
            10:      return 32'h000A2F98;
            11:      return 32'h000517CC;
            12:      return 32'h00028BE6;
            13:      return 32'h000145F3;
            14:      return 32'h0000A2FA;
            15:      return 32'h0000517D;
            16:      return 32'h000028BE;
            17:      return 32'h0000145F;
            18:      return 32'h00000A30;
            19:      return 32'h00000518;
            20:      return 32'h0000028C;
            21:      return 32'h00000146;
            22:      return 32'h000000A3;
            23:      return 32'h00000051;
            24:      return 32'h00000029;
            25:      return 32'h00000014;
            26:      return 32'h0000000A;
            27:      return 32'h00000005;
            28:      return 32'h00000003;
            29:      return 32'h00000001;
            30:      return 32'h00000001;
            default: return 32'h00000000;
        endcase
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_shift(input longint v, input int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    task automatic rotate_unit(input logic [31:0] angle, output longint cos_q30,
                               output longint sin_q30);
        logic [31:0] biased;
        logic [31:0] resid;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        biased = angle + 32'h20000000;
        resid  = angle - {biased[31:30], 30'd0};
        z = longint'($signed(resid));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(arctan_q30(i));
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(arctan_q30(i));
            end
        end
        case (biased[31:30])
            2'd0: begin
                cos_q30 = x;
                sin_q30 = y;
            end
            2'd1: begin
                cos_q30 = -y;
                sin_q30 = x;
            end
            2'd2: begin
                cos_q30 = -x;
                sin_q30 = -y;
            end
            default: begin
                cos_q30 = y;
                sin_q30 = -x;
            end
        endcase
    endtask

    task automatic advance_pose(input logic signed [15:0] spd, input logic signed [15:0] rate,
                                input logic [15:0] dt, output pose_t next);
        longint cos_q30;
        longint sin_q30;
        longint vx;
        longint vy;
        longint turn;
        rotate_unit(track_heading, cos_q30, sin_q30);
        vx = clamp(round_shift(longint'(spd) * cos_q30, 30), VEL_MIN, VEL_MAX);
        vy = clamp(round_shift(longint'(spd) * sin_q30, 30), VEL_MIN, VEL_MAX);
        track_x = clamp(track_x + round_shift(vx * longint'(dt), 12), POS_MIN, POS_MAX);
        track_y = clamp(track_y + round_shift(vy * longint'(dt), 12), POS_MIN, POS_MAX);
        turn = round_shift(longint'(rate) * longint'(dt) * RAD_TO_BAM_Q30, 30);
        track_heading = track_heading + turn[31:0];
        next.pos_x   = track_x[31:0];
        next.pos_y   = track_y[31:0];
        next.heading = track_heading;
        next.vel_x   = vx[15:0];
        next.vel_y   = vy[15:0];
    endtask

    task automatic report(input string what);
        failures++;
        if (failures <= 10)
            $display("pose_checker: result %0d: %s", results_seen, what);
    endtask

    always @(posedge i_clk) begin : watch
        pose_t fresh;
        pose_t want;
        if (!i_rst_n) begin
            expected_poses.delete();
            track_x       = 0;
            track_y       = 0;
            track_heading = '0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                advance_pose(i_speed, i_yaw_rate, i_elapsed, fresh);
                expected_poses.push_back(fresh);
            end
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_poses.size() == 0) begin
                    report("result arrived with nothing expected");
                end else begin
                    want = expected_poses.pop_front();
                    if (i_pos_x !== want.pos_x)
                        report($sformatf("pos_x expected %0d got %0d", want.pos_x, i_pos_x));
                    if (i_pos_y !== want.pos_y)
                        report($sformatf("pos_y expected %0d got %0d", want.pos_y, i_pos_y));
                    if (i_heading_out !== want.heading)
                        report($sformatf("heading_out expected %h got %h",
                                         want.heading, i_heading_out));
                    if (i_vel_x !== want.vel_x)
                        report($sformatf("vel_x expected %0d got %0d", want.vel_x, i_vel_x));
                    if (i_vel_y !== want.vel_y)
                        report($sformatf("vel_y expected %0d got %0d", want.vel_y, i_vel_y));
                end
            end
        end
        o_failures <= failures;
        o_pending  <= expected_poses.size();
    end

endmodule

FILE: verif/testbench.sv
// Testbench top for the pose integrator: clock, reset, odometry stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int CORDIC_STEPS  = 16;
    localparam int SAT_RUN       = 500;
    localparam int RANDOM_TICKS  = 975;
    localparam int HOLD_AT       = 1000;
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 64;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic signed [15:0] speed       = '0;
    logic signed [15:0] yaw_rate    = '0;
    logic        [15:0] elapsed     = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading_out;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               rx_hold     = 1'b0;
    bit                 tx_burst    = 1'b0;
    bit                 rx_burst    = 1'b0;
    int                 ticks_sent  = 0;
    int                 failures;
    int                 pending;

    dead_reckoning_pose_integrator #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_speed      (speed),
        .i_yaw_rate   (yaw_rate),
        .i_elapsed    (elapsed),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_pos_x      (pos_x),
        .o_pos_y      (pos_y),
        .o_heading_out(heading_out),
        .o_vel_x      (vel_x),
        .o_vel_y      (vel_y)
    );

    pose_checker #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) pose_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_speed      (speed),
        .i_yaw_rate   (yaw_rate),
        .i_elapsed    (elapsed),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_pos_x      (pos_x),
        .i_pos_y      (pos_y),
        .i_heading_out(heading_out),
        .i_vel_x      (vel_x),
        .i_vel_y      (vel_y),
        .o_failures   (failures),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_tick(input logic signed [15:0] spd, input logic signed [15:0] rate,
                             input logic [15:0] dt);
        int gap;
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        speed    <= spd;
        yaw_rate <= rate;
        elapsed  <= dt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ticks_sent++;
    endtask

    initial begin
        int                 k;
        logic signed [15:0] spd;
        logic signed [15:0] rate;
        logic        [15:0] dt;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // zero elapsed at heading zero, speed overflow included
        send_tick(16'sh8000, 16'sh0000, 16'd0);
        send_tick(16'sh7FFF, 16'sh0000, 16'd0);
        send_tick(16'sh0000, 16'sh8000, 16'd0);
        send_tick(16'sh0000, 16'sh7FFF, 16'd0);

        // drive x far out, then back
        repeat (SAT_RUN) send_tick(16'sh7FFF, 16'sh0000, 16'hFFFF);
        repeat (3) send_tick(16'sh8000, 16'sh0000, 16'd4096);

        // turn a quarter right, drive y far out, then back
        send_tick(16'sh0000, 16'sh8000, 16'd12868);
        repeat (SAT_RUN) send_tick(16'sh7FFF, 16'sh0000, 16'hFFFF);
        repeat (3) send_tick(16'sh8000, 16'sh0000, 16'd4096);

        // wrap the heading both ways
        repeat (2) send_tick(16'sh0000, 16'sh7FFF, 16'hFFFF);
        repeat (2) send_tick(16'sh0000, 16'sh8000, 16'hFFFF);
        send_tick(16'sh8000, 16'sh8000, 16'hFFFF);
        send_tick(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
        send_tick(16'sh0001, 16'shFFFF, 16'd1);
        send_tick(16'shFFFF, 16'sh0001, 16'd1);
        send_tick(16'sh5555, 16'shAAAA, 16'h5555);
        send_tick(16'shAAAA, 16'sh5555, 16'hAAAA);

        for (k = 0; k < RANDOM_TICKS; k++) begin
            spd  = 16'($urandom);
            rate = 16'($urandom);
            case ($urandom_range(0, 7))
                0:       dt = 16'd0;
                1:       dt = 16'hFFFF;
                2, 3:    dt = 16'($urandom_range(0, 255));
                default: dt = 16'($urandom);
            endcase
            if ($urandom_range(0, 15) == 0)
                spd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            send_tick(spd, rate, dt);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        for (k = 0; k < DRAIN_LIMIT && pending != 0; k++) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 11);
            if (gap > 0 || rx_hold) out_ready <= 1'b0;
            repeat (gap) @(posedge clk);
            while (rx_hold) @(posedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        wait (ticks_sent >= HOLD_AT);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #(64'd40_000_000);
        $display("testbench: errors");
        $finish;
    end

endmodule

FILE: dead_reckoning_pose_integrator.f
rtl/core/drpi_pkg.sv
rtl/core/dead_reckoning_pose_integrator.sv
verif/pose_checker.sv
verif/testbench.sv
